FILE: rtl/ssc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg: shared types and constants of the sonar sweep controller
// Command codes, status, LED and tone codes, register indexes and reset
// values used by the line buffer and the top level.
// ----------------------------------------------------------------------------
package ssc_pkg;

	// Default number of characters held in one command line.
	localparam int LINE_LENGTH_DEF = 2;

	// Request kinds on the input channel.
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Report kinds on the output channel.
	localparam logic REPORT_TICK   = 1'b0;
	localparam logic REPORT_STATUS = 1'b1;

	// Characters recognized on the command link.
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_ONE     = 8'h31;
	localparam logic [7:0] CHAR_AUTO    = 8'h61;
	localparam logic [7:0] CHAR_CTRL    = 8'h63;
	localparam logic [7:0] CHAR_MOVE    = 8'h6D;
	localparam logic [7:0] CHAR_RESET   = 8'h72;
	localparam logic [7:0] CHAR_SONAR   = 8'h73;

	// Command line status codes.
	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_TOO_LONG  = 2'd1;
	localparam logic [1:0] ST_NO_MANUAL = 2'd2;
	localparam logic [1:0] ST_UNKNOWN   = 2'd3;

	// LED selection codes.
	localparam logic [1:0] LED_BLUE  = 2'd0;
	localparam logic [1:0] LED_GREEN = 2'd1;
	localparam logic [1:0] LED_RED   = 2'd2;
	localparam logic [1:0] LED_NONE  = 2'd3;

	// Buzzer tone codes.
	localparam logic [1:0] TONE_OFF = 2'd0;
	localparam logic [1:0] TONE_2K  = 2'd1;
	localparam logic [1:0] TONE_4K  = 2'd2;
	localparam logic [1:0] TONE_6K  = 2'd3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_STEP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_LOW   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_HIGH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TONE_HIGH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TONE_MID    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOSE       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM      = 3'd6;

	// Configuration reset values.
	localparam logic [3:0]  RST_SWEEP_STEP = 4'd3;
	localparam logic [7:0]  RST_SWEEP_LOW  = 8'd5;
	localparam logic [7:0]  RST_SWEEP_HIGH = 8'd175;
	localparam logic [15:0] RST_TONE_HIGH  = 16'd291;
	localparam logic [15:0] RST_TONE_MID   = 16'd581;
	localparam logic [15:0] RST_CLOSE      = 16'd871;
	localparam logic [15:0] RST_MEDIUM     = 16'd1742;

	// Sweep angle limits and reset position.
	localparam logic [8:0] ANGLE_RESET = 9'd90;
	localparam logic [8:0] ANGLE_CAP   = 9'd180;
	localparam logic [8:0] ANGLE_SAT   = 9'd511;

	// Echo time to centimetres in Q8: echo * 1129 >> 8.
	localparam logic [10:0] DIST_MUL = 11'd1129;

	// Decoded command of a finished line.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_AUTO,
		OP_RESET,
		OP_SONAR,
		OP_CTRL,
		OP_MOVE
	} cmd_op_t;

	// Contents of the line buffer as seen by the command logic.
	typedef struct packed {
		cmd_op_t    op;
		logic       arg_one;
		logic [7:0] arg;
		logic       overflow;
	} line_cmd_t;

endpackage

FILE: rtl/sonar_sweep_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sonar_sweep_controller_top: servo sweep and sonar ranging controller
// Runs command lines from a serial link and, on each tick, steps the servo
// sweep and classifies the sonar echo into distance, LED and tone.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle. A request is captured in an
// input register and processed in the following cycle by single-pass logic
// (line buffer update, command decode, sweep step, one 16x11 multiply for the
// distance), which writes the report register. A report is therefore on the
// output right after the first clock edge that follows the edge accepting its
// request, as long as the report register is free at that edge. Ordinary
// characters produce no report; a newline produces a status report and a tick
// produces a tick report. The input stalls only while the input register holds
// a request and the report register holds a beat that the receiver is
// stalling. The configuration port is always ready and its registers should be
// written only while the block is idle.
module sonar_sweep_controller_top
	import ssc_pkg::*;
#(
	parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Request channel.
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic                 req_type,
	input  logic [7:0]           rx_byte,
	input  logic [15:0]          echo_time,
	// Report channel.
	output logic                 rpt_valid,
	input  logic                 rpt_stall,
	output logic                 report_kind,
	output logic [7:0]           servo_angle,
	output logic                 sonar_valid,
	output logic [18:0]          distance_q8,
	output logic [1:0]           led_select,
	output logic [1:0]           tone_choice,
	output logic [1:0]           cmd_status,
	output logic                 auto_flag,
	output logic                 manual_flag,
	output logic                 sonar_flag,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	// Configuration registers.
	logic [3:0]  sweep_step_q;
	logic [7:0]  sweep_low_q;
	logic [7:0]  sweep_high_q;
	logic [15:0] tone_high_q;
	logic [15:0] tone_mid_q;
	logic [15:0] close_q;
	logic [15:0] medium_q;

	// Input register.
	logic        valid_s1;
	logic        req_type_s1;
	logic [7:0]  rx_byte_s1;
	logic [15:0] echo_time_s1;

	// Controller state.
	logic [8:0]  angle_q;
	logic        down_q;
	logic        auto_q;
	logic        manual_q;
	logic        sonar_q;
	logic [1:0]  led_q;
	logic [1:0]  tone_q;

	// Report register.
	logic        valid_s2;
	logic        kind_s2;
	logic [7:0]  angle_s2;
	logic        meas_s2;
	logic [18:0] dist_s2;
	logic [1:0]  led_s2;
	logic [1:0]  tone_s2;
	logic [1:0]  status_s2;
	logic        auto_s2;
	logic        manual_s2;
	logic        sonar_s2;

	// Processing stage signals.
	logic        advance;
	logic        req_accept;
	logic        is_tick;
	logic        is_newline;
	logic        has_report;
	logic        byte_en;
	line_cmd_t   line_cmd;
	logic [9:0]  step_sum;
	logic [26:0] dist_prod;
	logic [8:0]  nxt_angle;
	logic        nxt_down;
	logic        nxt_auto;
	logic        nxt_manual;
	logic        nxt_sonar;
	logic [1:0]  nxt_led;
	logic [1:0]  nxt_tone;
	logic [1:0]  nxt_status;
	logic        nxt_meas;
	logic [18:0] nxt_dist;
	logic [7:0]  angle_out;

	// Handshake: the stage moves on whenever the report register is free.
	assign advance    = valid_s1 && (!valid_s2 || !rpt_stall);
	assign req_stall  = valid_s1 && !advance;
	assign req_accept = req_valid && !req_stall;
	assign cfg_ready  = 1'b1;

	assign is_tick    = (req_type_s1 == REQ_TICK);
	assign is_newline = (rx_byte_s1 == CHAR_NEWLINE);
	assign has_report = is_tick || is_newline;
	assign byte_en    = advance && !is_tick;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_step_q <= RST_SWEEP_STEP;
			sweep_low_q  <= RST_SWEEP_LOW;
			sweep_high_q <= RST_SWEEP_HIGH;
			tone_high_q  <= RST_TONE_HIGH;
			tone_mid_q   <= RST_TONE_MID;
			close_q      <= RST_CLOSE;
			medium_q     <= RST_MEDIUM;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SWEEP_STEP: sweep_step_q <= cfg_data[3:0];
				CFG_SWEEP_LOW:  sweep_low_q  <= cfg_data[7:0];
				CFG_SWEEP_HIGH: sweep_high_q <= cfg_data[7:0];
				CFG_TONE_HIGH:  tone_high_q  <= cfg_data;
				CFG_TONE_MID:   tone_mid_q   <= cfg_data;
				CFG_CLOSE:      close_q      <= cfg_data;
				CFG_MEDIUM:     medium_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_type_s1  <= req_type;
			rx_byte_s1   <= rx_byte;
			echo_time_s1 <= echo_time;
		end
	end

	// Command line buffer.
	ssc_cmd_line #(
		.LINE_LENGTH(LINE_LENGTH)
	) u_cmd_line (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_en  (byte_en),
		.rx_byte  (rx_byte_s1),
		.line_cmd (line_cmd)
	);

	// Distance in centimetres, Q8.
	assign dist_prod = 27'(echo_time_s1) * 27'(DIST_MUL);
	assign step_sum  = {1'b0, angle_q} + 10'(sweep_step_q);

	// Next state and report contents of the request in the stage.
	always_comb begin
		nxt_angle  = angle_q;
		nxt_down   = down_q;
		nxt_auto   = auto_q;
		nxt_manual = manual_q;
		nxt_sonar  = sonar_q;
		nxt_led    = led_q;
		nxt_tone   = tone_q;
		nxt_status = ST_DONE;
		nxt_meas   = 1'b0;
		nxt_dist   = '0;
		if (is_tick) begin
			// Sweep step, then turn at the high limit before the low limit.
			if (auto_q) begin
				if (down_q) begin
					nxt_angle = (angle_q >= 9'(sweep_step_q)) ?
						angle_q - 9'(sweep_step_q) : '0;
				end else begin
					nxt_angle = step_sum[9] ? ANGLE_SAT : step_sum[8:0];
				end
				if (nxt_angle >= {1'b0, sweep_high_q}) begin
					nxt_down = 1'b1;
				end else if (nxt_angle <= {1'b0, sweep_low_q}) begin
					nxt_down = 1'b0;
				end
			end
			// Echo classification; a medium echo keeps the previous tone.
			if (sonar_q) begin
				nxt_meas = 1'b1;
				nxt_dist = dist_prod[26:8];
				if (echo_time_s1 < close_q) begin
					nxt_led = LED_RED;
					if (echo_time_s1 < tone_high_q) begin
						nxt_tone = TONE_6K;
					end else if (echo_time_s1 < tone_mid_q) begin
						nxt_tone = TONE_4K;
					end else begin
						nxt_tone = TONE_2K;
					end
				end else if (echo_time_s1 < medium_q) begin
					nxt_led = LED_GREEN;
				end else begin
					nxt_led  = LED_BLUE;
					nxt_tone = TONE_OFF;
				end
			end
		end else if (is_newline) begin
			// Run the finished line unless it overflowed.
			if (line_cmd.overflow) begin
				nxt_status = ST_TOO_LONG;
			end else begin
				case (line_cmd.op)
					OP_AUTO: begin
						if (line_cmd.arg_one) begin
							nxt_manual = 1'b0;
							nxt_auto   = 1'b1;
						end else begin
							nxt_auto = 1'b0;
						end
					end
					OP_RESET: begin
						nxt_angle = {1'b0, sweep_low_q};
					end
					OP_SONAR: begin
						nxt_sonar = line_cmd.arg_one;
					end
					OP_CTRL: begin
						if (line_cmd.arg_one) begin
							nxt_auto   = 1'b0;
							nxt_manual = 1'b1;
						end else begin
							nxt_manual = 1'b0;
						end
					end
					OP_MOVE: begin
						if (!manual_q) begin
							nxt_status = ST_NO_MANUAL;
						end else if ({1'b0, line_cmd.arg} > ANGLE_CAP) begin
							nxt_angle = ANGLE_CAP;
						end else begin
							nxt_angle = {1'b0, line_cmd.arg};
						end
					end
					default: begin
						nxt_status = ST_UNKNOWN;
					end
				endcase
			end
		end
	end

	// Reported angle is clamped to the servo range.
	assign angle_out = (nxt_angle > ANGLE_CAP) ? ANGLE_CAP[7:0] : nxt_angle[7:0];

	// Controller state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q  <= ANGLE_RESET;
			down_q   <= 1'b0;
			auto_q   <= 1'b1;
			manual_q <= 1'b0;
			sonar_q  <= 1'b1;
			led_q    <= LED_NONE;
			tone_q   <= TONE_OFF;
		end else if (advance) begin
			angle_q  <= nxt_angle;
			down_q   <= nxt_down;
			auto_q   <= nxt_auto;
			manual_q <= nxt_manual;
			sonar_q  <= nxt_sonar;
			led_q    <= nxt_led;
			tone_q   <= nxt_tone;
		end
	end

	// Report register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= has_report;
		end else if (valid_s2 && !rpt_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// Report register payload.
	always_ff @(posedge clk) begin
		if (advance && has_report) begin
			kind_s2   <= is_tick ? REPORT_TICK : REPORT_STATUS;
			angle_s2  <= angle_out;
			meas_s2   <= nxt_meas;
			dist_s2   <= nxt_dist;
			led_s2    <= nxt_led;
			tone_s2   <= nxt_tone;
			status_s2 <= nxt_status;
			auto_s2   <= nxt_auto;
			manual_s2 <= nxt_manual;
			sonar_s2  <= nxt_sonar;
		end
	end

	assign rpt_valid   = valid_s2;
	assign report_kind = kind_s2;
	assign servo_angle = angle_s2;
	assign sonar_valid = meas_s2;
	assign distance_q8 = dist_s2;
	assign led_select  = led_s2;
	assign tone_choice = tone_s2;
	assign cmd_status  = status_s2;
	assign auto_flag   = auto_s2;
	assign manual_flag = manual_s2;
	assign sonar_flag  = sonar_s2;

	// Auto sweep and manual control are never on together.
	a_modes_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(auto_q && manual_q))
		else $error("auto and manual mode both on");

	// A new report only follows a request leaving the input register.
	a_report_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(advance))
		else $error("report appeared without a processed request");

	// A status report carries no measurement.
	a_status_no_meas: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && kind_s2 == REPORT_STATUS) |-> (!meas_s2 && dist_s2 == '0))
		else $error("status report carries a measurement");

	// The reported angle stays within the servo range.
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ({1'b0, angle_s2} <= ANGLE_CAP))
		else $error("reported angle out of range");

endmodule

FILE: rtl/ssc_cmd_line.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_cmd_line: command line buffer and decoder
// Collects received characters up to the line length, flags overlong
// lines, and presents the decoded command of the line held so far.
// ----------------------------------------------------------------------------
module ssc_cmd_line
	import ssc_pkg::*;
#(
	parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_en,
	input  logic [7:0] rx_byte,
	output line_cmd_t  line_cmd
);

	localparam int FILL_W = $clog2(LINE_LENGTH + 1);
	localparam int IDX_W  = (LINE_LENGTH > 1) ? $clog2(LINE_LENGTH) : 1;
	localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LINE_LENGTH);

	logic [7:0]        store_q [LINE_LENGTH];
	logic [FILL_W-1:0] fill_q;
	logic              overflow_q;
	logic              is_newline;
	logic              has_room;
	logic [7:0]        cmd_char;
	logic [7:0]        arg_char;

	assign is_newline = (rx_byte == CHAR_NEWLINE);
	assign has_room   = (fill_q < FILL_MAX);

	// Store characters; a newline empties the line for the next command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINE_LENGTH; i++) begin
				store_q[i] <= '0;
			end
			fill_q     <= '0;
			overflow_q <= 1'b0;
		end else if (byte_en) begin
			if (is_newline) begin
				for (int i = 0; i < LINE_LENGTH; i++) begin
					store_q[i] <= '0;
				end
				fill_q     <= '0;
				overflow_q <= 1'b0;
			end else if (has_room) begin
				store_q[fill_q[IDX_W-1:0]] <= rx_byte;
				fill_q                     <= fill_q + 1'b1;
			end else begin
				overflow_q <= 1'b1;
			end
		end
	end

	// The first character selects the command, the second is its argument.
	assign cmd_char = store_q[0];
	generate
		if (LINE_LENGTH > 1) begin : g_arg
			assign arg_char = store_q[1];
		end else begin : g_no_arg
			assign arg_char = 8'h00;
		end
	endgenerate

	// Decode the command character.
	always_comb begin
		line_cmd.arg      = arg_char;
		line_cmd.arg_one  = (arg_char == CHAR_ONE);
		line_cmd.overflow = overflow_q;
		case (cmd_char)
			CHAR_AUTO:  line_cmd.op = OP_AUTO;
			CHAR_RESET: line_cmd.op = OP_RESET;
			CHAR_SONAR: line_cmd.op = OP_SONAR;
			CHAR_CTRL:  line_cmd.op = OP_CTRL;
			CHAR_MOVE:  line_cmd.op = OP_MOVE;
			default:    line_cmd.op = OP_NONE;
		endcase
	end

endmodule

FILE: verif/sonar_report_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sonar_report_checker: scoreboard of the sonar sweep controller
// Watches the request, report and register write channels. It keeps its own
// copy of the line buffer, the modes, the sweep and the echo bands, predicts
// the report of every newline and tick beat and compares each report beat with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module sonar_report_checker
	import ssc_pkg::*;
#(
	parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	input  logic                 req_stall,
	input  logic                 req_type,
	input  logic [7:0]           rx_byte,
	input  logic [15:0]          echo_time,
	input  logic                 rpt_valid,
	input  logic                 rpt_stall,
	input  logic                 report_kind,
	input  logic [7:0]           servo_angle,
	input  logic                 sonar_valid,
	input  logic [18:0]          distance_q8,
	input  logic [1:0]           led_select,
	input  logic [1:0]           tone_choice,
	input  logic [1:0]           cmd_status,
	input  logic                 auto_flag,
	input  logic                 manual_flag,
	input  logic                 sonar_flag,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output int                   mismatches,
	output int                   pending,
	output int                   status_reports,
	output int                   tick_reports
);

	localparam int STORE_MAX = 8;
	localparam int FILL_MAX  = LINE_LENGTH > STORE_MAX ? STORE_MAX : LINE_LENGTH;

	// One report beat as the block should present it.
	typedef struct packed {
		logic        kind;
		logic [7:0]  angle;
		logic        measured;
		logic [18:0] dist_q8;
		logic [1:0]  led;
		logic [1:0]  tone;
		logic [1:0]  status;
		logic        auto_mode;
		logic        manual_mode;
		logic        sonar_mode;
	} sonar_report_t;

	// Register copy.
	logic [3:0]  step_deg;
	logic [7:0]  low_deg;
	logic [7:0]  high_deg;
	logic [15:0] tone_high_us;
	logic [15:0] tone_mid_us;
	logic [15:0] close_us;
	logic [15:0] medium_us;

	// Controller state.
	logic [8:0]  angle;
	logic        heading_down;
	logic        auto_mode;
	logic        manual_mode;
	logic        sonar_mode;
	logic [7:0]  line_chars [STORE_MAX];
	int          fill;
	logic        overflow;
	logic [1:0]  led;
	logic [1:0]  tone;

	// Scratch values of one prediction.
	logic [7:0]  cmd_char;
	logic [7:0]  arg_char;
	logic [1:0]  status;
	logic [9:0]  raised;
	logic [26:0] product;

	sonar_report_t expected_reports [$];
	sonar_report_t want;

	// Report fields as they follow from the present state.
	function automatic sonar_report_t snapshot(input logic kind, input logic measured,
		input logic [18:0] dist_in, input logic [1:0] code);
		sonar_report_t r;
		r.kind        = kind;
		r.angle       = angle > ANGLE_CAP ? ANGLE_CAP[7:0] : angle[7:0];
		r.measured    = measured;
		r.dist_q8     = dist_in;
		r.led         = led;
		r.tone        = tone;
		r.status      = code;
		r.auto_mode   = auto_mode;
		r.manual_mode = manual_mode;
		r.sonar_mode  = sonar_mode;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_val,
		input logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d",
				$time, name, exp_val, act_val);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_deg     = RST_SWEEP_STEP;
			low_deg      = RST_SWEEP_LOW;
			high_deg     = RST_SWEEP_HIGH;
			tone_high_us = RST_TONE_HIGH;
			tone_mid_us  = RST_TONE_MID;
			close_us     = RST_CLOSE;
			medium_us    = RST_MEDIUM;
			angle        = ANGLE_RESET;
			heading_down = 1'b0;
			auto_mode    = 1'b1;
			manual_mode  = 1'b0;
			sonar_mode   = 1'b1;
			for (int i = 0; i < STORE_MAX; i++)
				line_chars[i] = '0;
			fill         = 0;
			overflow     = 1'b0;
			led          = LED_NONE;
			tone         = TONE_OFF;
			mismatches   = 0;
			expected_reports.delete();
			pending        <= 0;
			status_reports <= 0;
			tick_reports   <= 0;
		end else begin
			// Compare the report beat taken at this edge with the oldest prediction.
			if (rpt_valid && !rpt_stall) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: report beat with nothing expected: kind %0d, angle %0d",
						$time, report_kind, servo_angle);
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_field("report_kind", 32'(want.kind), 32'(report_kind));
					check_field("servo_angle", 32'(want.angle), 32'(servo_angle));
					check_field("sonar_valid", 32'(want.measured), 32'(sonar_valid));
					check_field("distance_q8", 32'(want.dist_q8), 32'(distance_q8));
					check_field("led_select", 32'(want.led), 32'(led_select));
					check_field("tone_choice", 32'(want.tone), 32'(tone_choice));
					check_field("cmd_status", 32'(want.status), 32'(cmd_status));
					check_field("auto_flag", 32'(want.auto_mode), 32'(auto_flag));
					check_field("manual_flag", 32'(want.manual_mode), 32'(manual_flag));
					check_field("sonar_flag", 32'(want.sonar_mode), 32'(sonar_flag));
				end
				if (report_kind == REPORT_STATUS)
					status_reports <= status_reports + 1;
				else
					tick_reports <= tick_reports + 1;
			end

			// Register writes take effect before the request of the same edge.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SWEEP_STEP: step_deg     = cfg_data[3:0];
					CFG_SWEEP_LOW:  low_deg      = cfg_data[7:0];
					CFG_SWEEP_HIGH: high_deg     = cfg_data[7:0];
					CFG_TONE_HIGH:  tone_high_us = cfg_data;
					CFG_TONE_MID:   tone_mid_us  = cfg_data;
					CFG_CLOSE:      close_us     = cfg_data;
					CFG_MEDIUM:     medium_us    = cfg_data;
					default: ;
				endcase
			end

			// Character beats fill the line; a newline runs it and reports status.
			if (req_valid && !req_stall && req_type == REQ_BYTE) begin
				if (rx_byte != CHAR_NEWLINE) begin
					if (fill < FILL_MAX) begin
						line_chars[3'(fill)] = rx_byte;
						fill++;
					end else begin
						overflow = 1'b1;
					end
				end else begin
					cmd_char = line_chars[0];
					arg_char = line_chars[1];
					status   = ST_DONE;
					if (overflow) begin
						status = ST_TOO_LONG;
					end else begin
						case (cmd_char)
							CHAR_AUTO: begin
								if (arg_char == CHAR_ONE) begin
									manual_mode = 1'b0;
									auto_mode   = 1'b1;
								end else begin
									auto_mode = 1'b0;
								end
							end
							CHAR_RESET: angle = {1'b0, low_deg};
							CHAR_SONAR: sonar_mode = (arg_char == CHAR_ONE);
							CHAR_CTRL: begin
								if (arg_char == CHAR_ONE) begin
									auto_mode   = 1'b0;
									manual_mode = 1'b1;
								end else begin
									manual_mode = 1'b0;
								end
							end
							CHAR_MOVE: begin
								if (!manual_mode)
									status = ST_NO_MANUAL;
								else
									angle = {1'b0, arg_char} > ANGLE_CAP ?
										ANGLE_CAP : {1'b0, arg_char};
							end
							default: status = ST_UNKNOWN;
						endcase
					end
					for (int i = 0; i < STORE_MAX; i++)
						line_chars[i] = '0;
					fill     = 0;
					overflow = 1'b0;
					expected_reports.push_back(snapshot(REPORT_STATUS, 1'b0, '0, status));
				end
			end

			// A tick steps the sweep, then, in sonar mode, measures and classifies the echo.
			if (req_valid && !req_stall && req_type == REQ_TICK) begin
				if (auto_mode) begin
					if (heading_down) begin
						angle = angle >= 9'(step_deg) ? angle - 9'(step_deg) : '0;
					end else begin
						raised = {1'b0, angle} + 10'(step_deg);
						angle  = raised > {1'b0, ANGLE_SAT} ? ANGLE_SAT : raised[8:0];
					end
					if (angle >= {1'b0, high_deg})
						heading_down = 1'b1;
					else if (angle <= {1'b0, low_deg})
						heading_down = 1'b0;
				end
				if (sonar_mode) begin
					product = 27'(echo_time) * 27'(DIST_MUL);
					if (echo_time < close_us) begin
						led = LED_RED;
						if (echo_time < tone_high_us)
							tone = TONE_6K;
						else if (echo_time < tone_mid_us)
							tone = TONE_4K;
						else
							tone = TONE_2K;
					end else if (echo_time < medium_us) begin
						// A medium echo keeps whatever tone was sounding.
						led = LED_GREEN;
					end else begin
						led  = LED_BLUE;
						tone = TONE_OFF;
					end
					expected_reports.push_back(snapshot(REPORT_TICK, 1'b1, product[26:8],
						ST_DONE));
				end else begin
					expected_reports.push_back(snapshot(REPORT_TICK, 1'b0, '0, ST_DONE));
				end
			end

			pending <= expected_reports.size();
		end
	end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench of the sonar sweep controller
// Sends directed command lines and ticks, then random lines, noise and ticks
// under five register settings and three stall patterns, including long
// receiver hold-offs. A scoreboard beside the block checks every report.
// ----------------------------------------------------------------------------
module tb_top;
	import ssc_pkg::*;

	localparam int LINE_LENGTH  = LINE_LENGTH_DEF;
	localparam int PHASE_ITEMS  = 125;
	localparam int HOLD_CYCLES  = 60;
	localparam int QUIET_LIMIT  = 3000;
	localparam int SETTLE_CYCLES = 4;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	logic                 req_type;
	logic [7:0]           rx_byte;
	logic [15:0]          echo_time;
	logic                 rpt_valid;
	logic                 rpt_stall = 1'b0;
	logic                 report_kind;
	logic [7:0]           servo_angle;
	logic                 sonar_valid;
	logic [18:0]          distance_q8;
	logic [1:0]           led_select;
	logic [1:0]           tone_choice;
	logic [1:0]           cmd_status;
	logic                 auto_flag;
	logic                 manual_flag;
	logic                 sonar_flag;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;

	int mismatches;
	int pending;
	int status_reports;
	int tick_reports;

	int items_sent     = 0;
	int send_idle_pct  = 33;
	int recv_stall_pct = 72;
	int hold_orders    = 0;
	int holds_served   = 0;
	int hold_left      = 0;
	int quiet_cycles   = 0;
	logic [15:0] cfg_now [1 << CFG_IDX_W];

	always #6 clk = ~clk;

	sonar_sweep_controller_top #(
		.LINE_LENGTH(LINE_LENGTH)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
		.rx_byte(rx_byte), .echo_time(echo_time),
		.rpt_valid(rpt_valid), .rpt_stall(rpt_stall), .report_kind(report_kind),
		.servo_angle(servo_angle), .sonar_valid(sonar_valid), .distance_q8(distance_q8),
		.led_select(led_select), .tone_choice(tone_choice), .cmd_status(cmd_status),
		.auto_flag(auto_flag), .manual_flag(manual_flag), .sonar_flag(sonar_flag),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	sonar_report_checker #(
		.LINE_LENGTH(LINE_LENGTH)
	) u_scoreboard (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
		.rx_byte(rx_byte), .echo_time(echo_time),
		.rpt_valid(rpt_valid), .rpt_stall(rpt_stall), .report_kind(report_kind),
		.servo_angle(servo_angle), .sonar_valid(sonar_valid), .distance_q8(distance_q8),
		.led_select(led_select), .tone_choice(tone_choice), .cmd_status(cmd_status),
		.auto_flag(auto_flag), .manual_flag(manual_flag), .sonar_flag(sonar_flag),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending),
		.status_reports(status_reports), .tick_reports(tick_reports)
	);

	// Report side: random stalls, or a long hold-off when one is ordered.
	always @(posedge clk) begin
		if (holds_served != hold_orders) begin
			holds_served <= holds_served + 1;
			hold_left    <= HOLD_CYCLES;
			rpt_stall    <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rpt_stall <= 1'b1;
		end else begin
			rpt_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Watchdog: ends the run when no beat moves on any channel for too long.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rpt_valid && !rpt_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d reports outstanding",
				QUIET_LIMIT, pending);
			$display("sonar_sweep_controller_top regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one request beat after a random gap and holds it until taken.
	task automatic send_item(input logic kind, input logic [7:0] char_in,
		input logic [15:0] echo_in);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		rx_byte   <= char_in;
		echo_time <= echo_in;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_char(input logic [7:0] char_in);
		send_item(REQ_BYTE, char_in, 16'($urandom));
	endtask

	task automatic send_tick(input logic [15:0] echo_in);
		send_item(REQ_TICK, 8'($urandom), echo_in);
	endtask

	// Stops sending and waits until every report has come back.
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Any character except newline.
	function automatic logic [7:0] line_char();
		logic [7:0] c;
		c = 8'($urandom_range(255));
		return c == CHAR_NEWLINE ? 8'h00 : c;
	endfunction

	// Echo times spread over the whole range, near the band edges and at the ends.
	function automatic logic [15:0] pick_echo();
		logic [15:0] edge_us;
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(2047));
			2: begin
				edge_us = cfg_now[CFG_IDX_W'($urandom_range(CFG_TONE_HIGH, CFG_MEDIUM))];
				return edge_us + 16'($urandom_range(2)) - 16'd1;
			end
			default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
		endcase
	endfunction

	initial begin
		logic [7:0] cmd_char;
		int         roll;
		int         goal;

		arst_n    = 1'b0;
		req_valid = 1'b0;
		req_type  = REQ_BYTE;
		rx_byte   = '0;
		echo_time = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SWEEP_STEP;
		cfg_data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings: echo bands, the tone held
		// through a medium echo, an empty line, a move without manual control,
		// a saturated move, a short sonar argument and an overlong line.
		send_tick(16'h0000);
		send_tick(16'd1000);
		send_tick(16'hFFFF);
		send_tick(16'd600);
		send_char(CHAR_NEWLINE);
		send_char(CHAR_MOVE);
		send_char(CHAR_ONE);
		send_char(CHAR_NEWLINE);
		send_char(CHAR_CTRL);
		send_char(CHAR_ONE);
		send_char(CHAR_NEWLINE);
		send_char(CHAR_MOVE);
		send_char(8'hFF);
		send_char(CHAR_NEWLINE);
		send_tick(16'd400);
		send_char(CHAR_SONAR);
		send_char(CHAR_NEWLINE);
		send_tick(16'd100);
		send_char(CHAR_SONAR);
		send_char(CHAR_ONE);
		send_char(CHAR_NEWLINE);
		send_char(CHAR_RESET);
		send_char(8'h78);
		send_char(8'h79);
		send_char(CHAR_NEWLINE);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			// Register settings: range extremes, limits in the wrong order with
			// every band empty, every band full, and tone limits out of order.
			case (phase)
				0: begin
					cfg_now[CFG_SWEEP_STEP] = 16'd15;
					cfg_now[CFG_SWEEP_LOW]  = 16'd0;
					cfg_now[CFG_SWEEP_HIGH] = 16'd180;
					cfg_now[CFG_TONE_HIGH]  = 16'd100;
					cfg_now[CFG_TONE_MID]   = 16'd200;
					cfg_now[CFG_CLOSE]      = 16'd300;
					cfg_now[CFG_MEDIUM]     = 16'd400;
				end
				1: begin
					cfg_now[CFG_SWEEP_STEP] = 16'd1;
					cfg_now[CFG_SWEEP_LOW]  = 16'd180;
					cfg_now[CFG_SWEEP_HIGH] = 16'd0;
					cfg_now[CFG_TONE_HIGH]  = 16'd0;
					cfg_now[CFG_TONE_MID]   = 16'd0;
					cfg_now[CFG_CLOSE]      = 16'd0;
					cfg_now[CFG_MEDIUM]     = 16'd0;
				end
				2: begin
					cfg_now[CFG_SWEEP_STEP] = 16'd7;
					cfg_now[CFG_SWEEP_LOW]  = 16'd40;
					cfg_now[CFG_SWEEP_HIGH] = 16'd140;
					cfg_now[CFG_TONE_HIGH]  = 16'hFFFF;
					cfg_now[CFG_TONE_MID]   = 16'hFFFF;
					cfg_now[CFG_CLOSE]      = 16'hFFFF;
					cfg_now[CFG_MEDIUM]     = 16'hFFFF;
				end
				default: begin
					cfg_now[CFG_SWEEP_STEP] = 16'd4;
					cfg_now[CFG_SWEEP_LOW]  = 16'd10;
					cfg_now[CFG_SWEEP_HIGH] = 16'd170;
					cfg_now[CFG_TONE_HIGH]  = 16'd1000;
					cfg_now[CFG_TONE_MID]   = 16'd500;
					cfg_now[CFG_CLOSE]      = 16'd2000;
					cfg_now[CFG_MEDIUM]     = 16'd3000;
				end
			endcase

			// Stall pattern: receiver mostly stalling first, then sender mostly idle, then neither.
			if (phase == 1) begin
				send_idle_pct = 72;
				recv_stall_pct <= 33;
			end
			if (phase == 3) begin
				send_idle_pct = 0;
				recv_stall_pct <= 0;
			end

			// Register writes while the block is idle.
			for (int i = CFG_SWEEP_STEP; i <= CFG_MEDIUM; i++) begin
				cfg_valid <= 1'b1;
				cfg_index <= i[CFG_IDX_W-1:0];
				cfg_data  <= cfg_now[i[CFG_IDX_W-1:0]];
				@(posedge clk);
				while (!cfg_ready)
					@(posedge clk);
			end
			cfg_valid <= 1'b0;

			// The receiver holds off for a long stretch while requests keep coming.
			if (phase >= 2)
				hold_orders <= hold_orders + 1;

			// Mostly complete command lines with random content, plus ticks and noise.
			goal = items_sent + PHASE_ITEMS;
			while (items_sent < goal) begin
				roll = $urandom_range(99);
				if (roll < 40) begin
					send_tick(pick_echo());
				end else if (roll < 88) begin
					case ($urandom_range(6))
						0: cmd_char = CHAR_AUTO;
						1: cmd_char = CHAR_RESET;
						2: cmd_char = CHAR_SONAR;
						3: cmd_char = CHAR_CTRL;
						4: cmd_char = CHAR_MOVE;
						5: cmd_char = line_char();
						default: cmd_char = CHAR_NEWLINE;
					endcase
					if (cmd_char != CHAR_NEWLINE) begin
						send_char(cmd_char);
						roll = $urandom_range(99);
						if (roll < 50)
							send_char(CHAR_ONE);
						else if (roll < 80)
							send_char(line_char());
						if ($urandom_range(9) == 0)
							repeat ($urandom_range(1, 3)) send_char(line_char());
					end
					send_char(CHAR_NEWLINE);
				end else begin
					send_char(8'($urandom_range(255)));
				end
			end
			drain();
		end

		$display("Covered %0d requests with %0d status and %0d tick reports under five",
			items_sent, status_reports, tick_reports);
		$display("register settings, three stall patterns and two receiver hold-offs.");
		if (mismatches == 0 && pending == 0) begin
			$display("sonar_sweep_controller_top regression: pass");
		end else begin
			$display("sonar_sweep_controller_top regression: fail");
		end
		$finish;
	end

endmodule
